FILE: design/quantized_lcg_uniform_sampler_defines.svh
// Assertion macros for the quantized LCG uniform sampler.
`ifndef QUANTIZED_LCG_UNIFORM_SAMPLER_DEFINES_SVH
`define QUANTIZED_LCG_UNIFORM_SAMPLER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define QLUS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define QLUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/qlus_pkg.sv
// Shared constants and types of the quantized LCG uniform sampler.
`default_nettype none

package qlus_pkg;

  // Generator word and the bit count of the serial multiply
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned GEN_CNT_W = $clog2(GEN_W + 1);

  // LCG coefficients
  localparam logic [GEN_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [GEN_W-1:0] LCG_ADD = 32'd1013904223;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } qlus_stat_t;

endpackage

`default_nettype wire

FILE: design/qlus_lcg.sv
// Seed register and 32-bit linear congruential generator state.
`default_nettype none

module qlus_lcg import qlus_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [GEN_W-1:0] cfg_wdata_i,
  input  logic             reload_i,
  input  logic             advance_i,
  output logic [GEN_W-1:0] next_o
);

  logic [GEN_W-1:0] seed_q;
  logic [GEN_W-1:0] state_q;
  logic [GEN_W-1:0] state_d;

  // Next generator value, modulo 2^32
  assign next_o = state_q * LCG_MUL + LCG_ADD;

  // Load from a write, reload from seed, or advance
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = cfg_wdata_i;
    end else if (reload_i) begin
      state_d = seed_q;
    end else if (advance_i) begin
      state_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      state_q <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/qlus_smul.sv
// Bit-serial multiplier: floor(mult * mcand / 2^32) and a sticky remainder flag.
`default_nettype none

module qlus_smul import qlus_pkg::*; #(
  parameter int unsigned MW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [GEN_W-1:0] mult_i,
  input  logic [MW-1:0]    mcand_i,
  output qlus_stat_t       stat_o,
  output logic [MW-1:0]    prod_o,
  output logic             sticky_o
);

  logic [GEN_W-1:0]     mult_q;
  logic [MW-1:0]        mcand_q;
  logic [MW-1:0]        acc_q;
  logic                 sticky_q;
  logic [GEN_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [MW:0]          sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, acc_q} + (mult_q[0] ? {1'b0, mcand_q} : '0);

  // Control: count one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= GEN_CNT_W'(GEN_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - GEN_CNT_W'(1);
        if (cnt_q == GEN_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the partial product right, collect dropped bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mult_q   <= mult_i;
      mcand_q  <= mcand_i;
      acc_q    <= '0;
      sticky_q <= 1'b0;
    end else if (busy_q) begin
      acc_q    <= sum[MW:1];
      sticky_q <= sticky_q | sum[0];
      mult_q   <= mult_q >> 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;
  assign sticky_o    = sticky_q;

endmodule

`default_nettype wire

FILE: design/qlus_smod.sv
// Bit-serial restoring remainder unit: num mod den, one dividend bit per cycle.
`default_nettype none

module qlus_smod import qlus_pkg::*; #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output qlus_stat_t    stat_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Bring in the next dividend bit and try a subtraction
  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  // Control: count one dividend bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the partial remainder, restore when the trial goes negative
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

FILE: design/quantized_lcg_uniform_sampler.sv
// Top level of the quantized LCG uniform sampler.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    restart, enabled, minimum,
//                                                  maximum, step, current_value
//   out      output     out_valid_o / out_stall_i  sample_value
//   cfg      input      cfg_we_i                   cfg_wdata_i (seed)
//
// One item at a time. A disabled item goes from acceptance straight to the done
// state and then to the output register; an enabled item with step <= 0 passes
// the generator step and the 32 steps of the bit-serial scaling multiply; with
// step > 0 it also passes the VALUE_WIDTH + 2 steps of the bit-serial remainder
// unit, then the snap and the clamp.
// Reset clears generator, seed and control at once; no clearing pass.
// A stalled result waits in the output register; the next item is accepted and
// worked on meanwhile, and waits in its final state until the register is free.
`default_nettype none
`include "quantized_lcg_uniform_sampler_defines.svh"

module quantized_lcg_uniform_sampler import qlus_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [GEN_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   restart_i,
  input  logic                   enabled_i,
  input  logic signed [VALUE_WIDTH-1:0] minimum_i,
  input  logic signed [VALUE_WIDTH-1:0] maximum_i,
  input  logic signed [VALUE_WIDTH-1:0] step_i,
  input  logic signed [VALUE_WIDTH-1:0] current_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] sample_value_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned XW = VALUE_WIDTH + 2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LCG   = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_PREP  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_SNAP  = 8'b0010_0000,
    S_CLAMP = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q;
  state_e state_d;

  logic                 in_acc;
  logic                 slot_free;
  logic                 step_pos;

  logic [W:0]           d_full;
  logic [W-1:0]         mag_d;

  logic signed [W-1:0]  lo_q;
  logic signed [W-1:0]  hi_q;
  logic signed [W-1:0]  step_q;
  logic                 dneg_q;
  logic [W-1:0]         mag_q;
  logic [W-1:0]         offm_q;
  logic [XW-1:0]        n_q;
  logic [W:0]           offq_q;
  logic signed [XW-1:0] snap_q;
  logic [W-1:0]         res_q;
  logic [W-1:0]         out_q;
  logic                 out_valid_q;

  logic signed [XW-1:0] lo_x;
  logic signed [XW-1:0] hi_x;
  logic signed [XW-1:0] v_x;
  logic signed [XW-1:0] c1;
  logic signed [XW-1:0] c2;
  logic [XW-1:0]        n_d;
  logic [XW-1:0]        nr;

  logic [GEN_W-1:0]     gen_next;
  qlus_stat_t           mul_st;
  logic [W-1:0]         mul_prod;
  logic                 mul_sticky;
  qlus_stat_t           div_st;
  logic [W-1:0]         div_rem;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Span of the bounds and its magnitude
  assign d_full = {maximum_i[W-1], maximum_i} - {minimum_i[W-1], minimum_i};
  assign mag_d  = d_full[W] ? '0 - d_full[W-1:0] : d_full[W-1:0];

  // Bounds widened for the snap and clamp arithmetic
  assign lo_x     = {{2{lo_q[W-1]}}, lo_q};
  assign hi_x     = {{2{hi_q[W-1]}}, hi_q};
  assign step_pos = !step_q[W-1] && (|step_q);

  // Drawn value, and dividend 2*|offset| + step for the rounding
  assign v_x = dneg_q ? lo_x - {2'b00, offm_q} : lo_x + {2'b00, offm_q};
  assign n_d = {1'b0, offm_q, 1'b0} + {2'b00, step_q};
  assign nr  = n_q - {2'b00, div_rem};

  // Clamp to minimum, then to maximum
  assign c1 = (snap_q < lo_x) ? lo_x : snap_q;
  assign c2 = (c1 > hi_x) ? hi_x : c1;

  qlus_lcg u_lcg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .reload_i    (in_acc && restart_i),
    .advance_i   (state_q == S_LCG),
    .next_o      (gen_next)
  );

  qlus_smul #(.MW(W)) u_smul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_LCG),
    .mult_i   (gen_next),
    .mcand_i  (mag_q),
    .stat_o   (mul_st),
    .prod_o   (mul_prod),
    .sticky_o (mul_sticky)
  );

  qlus_smod #(.NW(XW), .DW(W)) u_smod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_PREP) && step_pos),
    .num_i   (n_d),
    .den_i   ({step_q[W-2:0], 1'b0}),
    .stat_o  (div_st),
    .rem_o   (div_rem)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = enabled_i ? S_LCG : S_DONE;
        end
      end
      S_LCG: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        if (mul_st.done) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = step_pos ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_st.done) begin
          state_d = S_SNAP;
        end
      end
      S_SNAP: begin
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers: state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the item at work
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lo_q   <= minimum_i;
      hi_q   <= maximum_i;
      step_q <= step_i;
      dneg_q <= d_full[W];
      mag_q  <= mag_d;
      res_q  <= current_value_i;
    end
    if ((state_q == S_MUL) && mul_st.done) begin
      offm_q <= mul_prod + {{(W-1){1'b0}}, dneg_q & mul_sticky};
    end
    if (state_q == S_PREP) begin
      res_q <= v_x[W-1:0];
      n_q   <= n_d;
    end
    if ((state_q == S_DIV) && div_st.done) begin
      offq_q <= nr[XW-1:1];
    end
    if (state_q == S_SNAP) begin
      snap_q <= dneg_q ? lo_x - {1'b0, offq_q} : lo_x + {1'b0, offq_q};
    end
    if (state_q == S_CLAMP) begin
      res_q <= c2[W-1:0];
    end
    if ((state_q == S_DONE) && slot_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_q;

  `QLUS_ASSERT_SAME(a_mul_in_state, mul_st.busy, state_q == S_MUL, "multiplier busy")
  `QLUS_ASSERT_SAME(a_div_in_state, div_st.busy, state_q == S_DIV, "remainder unit busy")
  `QLUS_ASSERT_NEXT(a_accept_next, in_acc, state_q == S_LCG || state_q == S_DONE, "bad state")
  `QLUS_ASSERT_NEXT(a_result_loaded, state_q == S_DONE && slot_free, out_valid_o, "no result")

endmodule

`default_nettype wire

FILE: verif/quantized_lcg_uniform_sampler_test.sv
// Self-checking testbench for the quantized LCG uniform sampler.
`default_nettype none

module quantized_lcg_uniform_sampler_test;
  import qlus_pkg::*;

  localparam int unsigned VW         = 32;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RAND_ITEMS = 220;
  localparam int unsigned N_PHASES   = 6;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE  = VW'(32'sh0001_0000);

  typedef struct {
    logic                 restart;
    logic                 enabled;
    logic signed [VW-1:0] minimum;
    logic signed [VW-1:0] maximum;
    logic signed [VW-1:0] step;
    logic signed [VW-1:0] current_value;
  } sample_req_t;

  // Own copy of seed and generator; queue of samples still to come
  class sample_scoreboard;
    logic [GEN_W-1:0]     seed_reg;
    logic [GEN_W-1:0]     lcg_state;
    logic signed [VW-1:0] expected_samples[$];
    int unsigned          errors;
    int unsigned          checked;

    function new();
      seed_reg  = '0;
      lcg_state = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    // A seed write loads the generator at once
    function void load_seed(logic [GEN_W-1:0] value);
      seed_reg  = value;
      lcg_state = value;
    endfunction

    // Reload on restart; if enabled, advance, draw, and for step > 0 snap to the grid and clamp
    function logic signed [VW-1:0] predict_sample(sample_req_t it);
      logic signed [127:0] lo, hi, span, pos, offs, mg, qstep, cnt, off, v;
      if (it.restart) lcg_state = seed_reg;
      if (!it.enabled) return it.current_value;
      lcg_state = lcg_state * LCG_MUL + LCG_ADD;
      lo    = $signed(it.minimum);
      hi    = $signed(it.maximum);
      qstep = $signed(it.step);
      span  = hi - lo;
      pos   = $signed({96'd0, lcg_state});
      // exact floor of state * span / 2^32
      v = lo + ((pos * span) >>> 32);
      if (qstep > 0) begin
        offs = v - lo;
        mg   = (offs < 0) ? -offs : offs;
        cnt  = (mg * 2 + qstep) / (qstep * 2);
        off  = cnt * qstep;
        if (offs < 0) off = -off;
        v = lo + off;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
      end
      return v[VW-1:0];
    endfunction

    function void note_item(sample_req_t it);
      logic signed [VW-1:0] want;
      want = predict_sample(it);
      expected_samples.insert(expected_samples.size(), want);
    endfunction

    function void check_result(logic signed [VW-1:0] got);
      logic signed [VW-1:0] want;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: sample_value mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [GEN_W-1:0]     cfg_wdata_i     = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic                 restart_i       = 1'b0;
  logic                 enabled_i       = 1'b0;
  logic signed [VW-1:0] minimum_i       = '0;
  logic signed [VW-1:0] maximum_i       = '0;
  logic signed [VW-1:0] step_i          = '0;
  logic signed [VW-1:0] current_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic signed [VW-1:0] sample_value_o;

  sample_scoreboard board = new();

  int unsigned send_mode  = 1;
  int unsigned stall_mode = 1;
  int          burst_left = 1;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_items = 0, n_enabled = 0, n_quantised = 0, n_restarts = 0, n_seeds = 0;

  quantized_lcg_uniform_sampler #(.VALUE_WIDTH(VW)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .restart_i       (restart_i),
    .enabled_i       (enabled_i),
    .minimum_i       (minimum_i),
    .maximum_i       (maximum_i),
    .step_i          (step_i),
    .current_value_i (current_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_value_o  (sample_value_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Check every sample taken from the output
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(sample_value_o);
  end

  // Stall the output: never, in short flickers, or in long stretches
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
          stall_left = $urandom_range(8, 64);
        end
        1: begin
          out_stall_i <= 1'($urandom_range(0, 1));
          stall_left = $urandom_range(0, 2);
        end
        default: begin
          out_stall_i <= !out_stall_i;
          stall_left = out_stall_i ? $urandom_range(0, 8) : $urandom_range(4, 40);
        end
      endcase
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d samples pending", idle_cycles, board.pending());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void new_burst();
    case (send_mode)
      0:       burst_left = 1_000_000;
      1:       burst_left = $urandom_range(1, 4);
      default: burst_left = $urandom_range(1, 20);
    endcase
  endfunction

  // Offer one item and hold it until accepted
  task automatic push_item(input sample_req_t it);
    in_valid_i      <= 1'b1;
    restart_i       <= it.restart;
    enabled_i       <= it.enabled;
    minimum_i       <= it.minimum;
    maximum_i       <= it.maximum;
    step_i          <= it.step;
    current_value_i <= it.current_value;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(it);
    n_items++;
    if (it.restart) n_restarts++;
    if (it.enabled) n_enabled++;
    if (it.enabled && it.step > 0) n_quantised++;
  endtask

  // Drop valid between bursts; leave it low after the last item
  task automatic after_item(input bit last);
    int unsigned gap;
    burst_left--;
    if (last) begin
      in_valid_i <= 1'b0;
    end else if (burst_left <= 0) begin
      new_burst();
      gap = (send_mode == 0) ? 0 : $urandom_range(0, (send_mode == 1) ? 3 : 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Write the seed; it takes effect at the edge with the enable high
  task automatic write_seed(input logic [GEN_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.load_seed(value);
    cfg_we_i    <= 1'b0;
    n_seeds++;
  endtask

  function automatic sample_req_t make_req(logic rs, logic en, logic signed [VW-1:0] lo,
                                           logic signed [VW-1:0] hi, logic signed [VW-1:0] st,
                                           logic signed [VW-1:0] cur);
    sample_req_t it;
    it.restart       = rs;
    it.enabled       = en;
    it.minimum       = lo;
    it.maximum       = hi;
    it.step          = st;
    it.current_value = cur;
    return it;
  endfunction

  // Corner cases: bounds, steps, reversed ranges, restarts, rounding ties
  function automatic sample_req_t corner_item(int idx);
    case (idx)
      0:  return make_req(0, 0, 0, ONE, ONE, VMIN);
      1:  return make_req(1, 0, VMIN, VMAX, ONE, VMAX);          // restart while disabled
      2:  return make_req(0, 1, VMIN, VMAX, 0, 0);
      3:  return make_req(0, 1, VMIN, VMAX, -1, 0);              // negative step, no snapping
      4:  return make_req(0, 1, VMIN, VMAX, VMIN, 0);
      5:  return make_req(0, 1, -10 * ONE, 10 * ONE, ONE, 0);
      6:  return make_req(0, 1, 5 * ONE, -5 * ONE, ONE, 0);      // reversed bounds, clamp to max
      7:  return make_req(0, 1, 5 * ONE, -5 * ONE, 0, 0);        // reversed bounds, raw draw
      8:  return make_req(0, 1, 3 * ONE, 3 * ONE, ONE, 0);
      9:  return make_req(0, 1, 0, 3 * ONE, VMAX, 0);            // step wider than the range
      10: return make_req(0, 1, VMIN, VMAX, 1, 0);
      11: return make_req(1, 1, VMIN, VMAX, VMAX, 0);
      12: return make_req(0, 1, VMAX, VMAX, 1, 0);
      13: return make_req(0, 1, VMIN, VMIN, 0, 0);
      14: return make_req(1, 1, VMIN, VMAX, 3, -1);
      15: return make_req(0, 1, VMAX, VMIN, ONE, 0);              // extreme reversed bounds
      16: return make_req(0, 1, VMAX, VMIN, 0, 0);
      17: return make_req(0, 1, -1, 0, 1, 0);
      18: return make_req(0, 1, 0, 3, 2, 0);                     // half-way ties
      19: return make_req(0, 1, -3, 0, 2, 0);
      20: return make_req(0, 1, 0, 4, 2, 0);
      default: return make_req(0, 0, VMAX, VMIN, VMIN, 0);
    endcase
  endfunction

  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 4))
      0, 4: return VW'($urandom());
      1:    return $signed(VW'($urandom_range(0, 32'h001F_FFFF))) - VW'(32'sh0010_0000);
      2: begin
        case ($urandom_range(0, 4))
          0:       return VMIN;
          1:       return VMAX;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default: return ($signed(VW'($urandom_range(0, 2000))) - 1000) * ONE;
    endcase
  endfunction

  // Mostly ordered bounds with a step scaled to the range; some noise
  function automatic sample_req_t random_item();
    sample_req_t it;
    logic signed [VW-1:0] a, b, t;
    longint span, lim;
    a = pick_value();
    b = pick_value();
    if ($urandom_range(0, 9) != 0 && a > b) begin
      t = a;
      a = b;
      b = t;
    end
    it.restart       = ($urandom_range(0, 19) == 0);
    it.enabled       = ($urandom_range(0, 5) != 0);
    it.minimum       = a;
    it.maximum       = b;
    it.current_value = pick_value();
    span = longint'(b) - longint'(a);
    if (span < 0) span = -span;
    case ($urandom_range(0, 7))
      0: it.step = 0;
      1: it.step = VMIN | VW'($urandom());
      2: it.step = VW'($urandom());
      default: begin
        lim = span >> $urandom_range(0, 12);
        if (lim < 1) lim = 1;
        if (lim > longint'(VMAX)) lim = longint'(VMAX);
        it.step = VW'($urandom_range(1, 32'(lim)));
      end
    endcase
    return it;
  endfunction

  initial begin
    logic [GEN_W-1:0] seed_val;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner cases from the reset seed
    new_burst();
    for (int k = 0; k < 22; k++) begin
      push_item(corner_item(k));
      after_item(k == 21);
    end
    wait_drained();

    // Random phases, each after a fresh seed with its own idling pattern
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       seed_val = '1;
        1:       seed_val = '0;
        default: seed_val = $urandom();
      endcase
      send_mode  = p % 3;
      stall_mode = (p + 1) % 3;
      write_seed(seed_val);
      new_burst();
      for (int k = 0; k < RAND_ITEMS; k++) begin
        push_item(random_item());
        after_item(k == RAND_ITEMS - 1);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    $display("Sent %0d items: %0d enabled, %0d snapped to a step, %0d restarts",
             n_items, n_enabled, n_quantised, n_restarts);
    $display("Checked %0d samples over %0d seed writes, %0d samples left over",
             board.checked, n_seeds, board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
